### rtl/pdg_pkg.sv
// package for the point or directional gravity unit
// holds default widths and configuration register indexes
// no dependencies
package pdg_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int NUM_REGS        = 6;
  localparam int REG_IDX_W       = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_STRENGTH = 3'd0,
    REG_VEC_X    = 3'd1,
    REG_VEC_Y    = 3'd2,
    REG_VEC_Z    = 3'd3,
    REG_POINT    = 3'd4,
    REG_UDIST    = 3'd5
  } reg_idx_t;

endpackage

### rtl/pdg_sqrt.sv
// pipelined integer square root, one result bit per stage
// radicand is carried alongside the root; no package dependencies
module pdg_sqrt #(
  parameter int RW = 33
) (
  input  logic              clk,
  input  logic              en,
  input  logic [2*RW-1:0]   rad_i,
  output logic [RW-1:0]     root_o,
  output logic [2*RW-1:0]   rad_o
);

  localparam int QW = 2 * RW;

  logic [QW-1:0] rem_r  [RW-1];
  logic [RW-1:0] root_r [RW];
  logic [QW-1:0] rad_r  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_st
    localparam int I = RW - 1 - k;
    logic [QW-1:0] rem_in;
    logic [QW-1:0] rad_in;
    logic [QW-1:0] trial;
    logic [RW-1:0] root_in;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in  = rad_i;
      assign rad_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign root_in = root_r[k-1];
    end

    assign trial = (QW'(root_in) << (I + 1)) | (QW'(1) << (2 * I));
    assign take  = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= take ? (root_in | (RW'(1) << I)) : root_in;
        rad_r[k]  <= rad_in;
      end
    end

    if (k < RW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= take ? (rem_in - trial) : rem_in;
        end
      end
    end
  end

  assign root_o = root_r[RW-1];
  assign rad_o  = rad_r[RW-1];

endmodule

### rtl/pdg_div.sv
// pipelined restoring divider: overflow check stage, then one quotient bit per stage
// quotient is QB bits, ovf flags a quotient of 2^QB or more; no package dependencies
module pdg_div #(
  parameter int NW = 129,
  parameter int DW = 99,
  parameter int QB = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QB-1:0] quo_o,
  output logic          ovf_o
);

  localparam int CW = (NW > DW + QB) ? NW : DW + QB;

  logic [NW-1:0] rem_r [QB];
  logic [DW-1:0] den_r [QB];
  logic [QB-1:0] quo_r [QB];
  logic          ovf_r [QB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num_i;
      den_r[0] <= den_i;
      ovf_r[0] <= CW'(num_i) >= (CW'(den_i) << QB);
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_st
    localparam int B = QB - k;
    logic [CW-1:0] shifted;
    logic [QB-1:0] q_in;
    logic          take;

    if (k == 1) begin : g_first
      assign q_in = '0;
    end else begin : g_next
      assign q_in = quo_r[k-2];
    end

    assign shifted = CW'(den_r[k-1]) << B;
    assign take    = CW'(rem_r[k-1]) >= shifted;

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k-1] <= take ? (q_in | (QB'(1) << B)) : q_in;
        ovf_r[k]   <= ovf_r[k-1];
      end
    end

    if (k < QB) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= take ? NW'(CW'(rem_r[k-1]) - shifted) : rem_r[k-1];
          den_r[k] <= den_r[k-1];
        end
      end
    end
  end

  assign quo_o = quo_r[QB-1];
  assign ovf_o = ovf_r[QB];

endmodule

### rtl/point_or_directional_gravity_unit.sv
// top level of the point or directional gravity unit
// uses pdg_pkg, pdg_sqrt and pdg_div
//
// usage: software loads strength, vector, mode and unit distance over the
// apb-style port while no item is in flight. each item on the in_ channel is
// one body position; the out_ channel returns one gravity vector and a
// saturation flag per item, in order.
// directional mode: vector times strength. point mode: toward the center,
// full strength, or inverse-square falloff scaled by a positive unit distance.
// from accept to out_valid an item passes, in order, through
// three front stages, one square root stage per root bit, two multiply
// stages, the divider's overflow stage plus one stage per quotient bit,
// and the output register.
// throughput is one item per cycle. the whole pipeline advances while the
// output register is empty or being taken; when the receiver stalls with a
// result waiting, every stage holds and in_ready drops, nothing is lost.
// reset clears all valid bits and the configuration registers.
module point_or_directional_gravity_unit
  #(
  parameter int  FRAC_BITS   = pdg_pkg::FRAC_BITS_DEF,
  parameter int  COORD_WIDTH = pdg_pkg::COORD_WIDTH_DEF,
  localparam int DATA_W      = (COORD_WIDTH > 32) ? 64 : 32,
  localparam int ADDR_SH     = (COORD_WIDTH > 32) ? 3 : 2,
  localparam int ADDR_W      = ADDR_SH + pdg_pkg::REG_IDX_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_pos_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_grav_x,
  output logic signed [COORD_WIDTH-1:0] out_grav_y,
  output logic signed [COORD_WIDTH-1:0] out_grav_z,
  output logic                          out_saturated
);

  import pdg_pkg::*;

  localparam int W     = COORD_WIDTH;
  localparam int VW    = W + 1;
  localparam int RW    = W + 1;
  localparam int QW    = 2 * RW;
  localparam int KW    = 3 * W;
  localparam int NW    = VW + KW;
  localparam int DENW  = QW + RW;
  localparam int NPW   = VW + W;
  localparam int P     = 5 + RW + W + 1;

  typedef struct packed {
    logic [2:0][VW-1:0] mag;
    logic [2:0]         neg;
    logic               zero;
  } sq_side_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } dv_side_t;

  // configuration registers
  logic [W-1:0]          strength_r;
  logic [2:0][W-1:0]     vec_r;
  logic                  point_r;
  logic [W-1:0]          udist_r;
  logic [REG_IDX_W-1:0]  idx;
  logic                  wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:ADDR_SH];
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strength_r <= '0;
      vec_r      <= '0;
      point_r    <= 1'b0;
      udist_r    <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_STRENGTH: strength_r <= pwdata[W-1:0];
        REG_VEC_X:    vec_r[0]   <= pwdata[W-1:0];
        REG_VEC_Y:    vec_r[1]   <= pwdata[W-1:0];
        REG_VEC_Z:    vec_r[2]   <= pwdata[W-1:0];
        REG_POINT:    point_r    <= pwdata[0];
        REG_UDIST:    udist_r    <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_STRENGTH: prdata = DATA_W'($signed(strength_r));
      REG_VEC_X:    prdata = DATA_W'($signed(vec_r[0]));
      REG_VEC_Y:    prdata = DATA_W'($signed(vec_r[1]));
      REG_VEC_Z:    prdata = DATA_W'($signed(vec_r[2]));
      REG_POINT:    prdata = DATA_W'(point_r);
      REG_UDIST:    prdata = DATA_W'($signed(udist_r));
      default:      prdata = '0;
    endcase
  end

  // scale factor from configuration: |s| or |s|*d*d
  logic              falloff;
  logic [W-1:0]      sabs_r;
  logic [2*W-3:0]    dd_r;
  logic [2*W-1:0]    kp_lo_r;
  logic [2*W-3:0]    kp_hi_r;
  logic [KW-1:0]     k_r;

  assign falloff = point_r & ~udist_r[W-1] & (|udist_r);

  always_ff @(posedge clk) begin
    sabs_r  <= strength_r[W-1] ? (W'(0) - strength_r) : strength_r;
    dd_r    <= (2*W-2)'(udist_r[W-2:0]) * (2*W-2)'(udist_r[W-2:0]);
    kp_lo_r <= (2*W)'(sabs_r) * (2*W)'(dd_r[W-1:0]);
    kp_hi_r <= (2*W-2)'(sabs_r) * (2*W-2)'(dd_r[2*W-3:W]);
    k_r     <= falloff ? ((KW'(kp_hi_r) << W) + KW'(kp_lo_r)) : KW'(sabs_r);
  end

  // pipeline control
  logic         en;
  logic [P-1:0] vld_r;
  logic         out_valid_r;

  assign en        = out_ready | ~out_valid_r;
  assign in_ready  = en;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[P-2:0], in_valid};
      out_valid_r <= vld_r[P-1];
    end
  end

  // stage 1: difference (point mode) or direction vector magnitude and result sign
  logic [2:0][W-1:0]  pos;
  logic [2:0][VW-1:0] mag1_r;
  logic [2:0]         neg1_r;
  logic [2:0][VW-1:0] mag1_nxt;
  logic [2:0]         neg1_nxt;

  assign pos = {in_pos_z, in_pos_y, in_pos_x};

  always_comb begin
    logic signed [VW-1:0] v;
    for (int i = 0; i < 3; i++) begin
      if (point_r) begin
        v = VW'($signed(vec_r[i])) - VW'($signed(pos[i]));
      end else begin
        v = VW'($signed(vec_r[i]));
      end
      mag1_nxt[i] = v[VW-1] ? VW'(-v) : VW'(v);
      neg1_nxt[i] = v[VW-1] ^ strength_r[W-1];
    end
  end

  // stage 2: squares, stage 3: sum of squares
  logic [2:0][QW-1:0] sq2_r;
  logic [2:0][VW-1:0] mag2_r;
  logic [2:0]         neg2_r;
  logic [QW-1:0]      q3_r;
  logic [QW-1:0]      q3_nxt;
  sq_side_t           side3_r;

  assign q3_nxt = sq2_r[0] + sq2_r[1] + sq2_r[2];

  always_ff @(posedge clk) begin
    if (en) begin
      mag1_r <= mag1_nxt;
      neg1_r <= neg1_nxt;
      for (int i = 0; i < 3; i++) begin
        sq2_r[i] <= QW'(mag1_r[i]) * QW'(mag1_r[i]);
      end
      mag2_r        <= mag1_r;
      neg2_r        <= neg1_r;
      q3_r          <= q3_nxt;
      side3_r.mag   <= mag2_r;
      side3_r.neg   <= neg2_r;
      side3_r.zero  <= point_r & (q3_nxt == '0);
    end
  end

  // square root with side data delayed alongside
  logic [RW-1:0] root;
  logic [QW-1:0] rad;
  sq_side_t      sq_side_r [RW];

  pdg_sqrt #(.RW(RW)) u_sqrt (
    .clk    (clk),
    .en     (en),
    .rad_i  (q3_r),
    .root_o (root),
    .rad_o  (rad)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sq_side_r[0] <= side3_r;
      for (int j = 1; j < RW; j++) begin
        sq_side_r[j] <= sq_side_r[j-1];
      end
    end
  end

  // multiply stage 1: partial products
  logic [2*RW-1:0]          dlo_r;
  logic [2*RW-1:0]          dhi_r;
  logic [RW-1:0]            root_m1_r;
  logic [2:0][2:0][NPW-1:0] np_r;
  dv_side_t                 side_m1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dlo_r     <= (2*RW)'(rad[RW-1:0]) * (2*RW)'(root);
      dhi_r     <= (2*RW)'(rad[QW-1:RW]) * (2*RW)'(root);
      root_m1_r <= root;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          np_r[i][j] <= NPW'(sq_side_r[RW-1].mag[i]) * NPW'(k_r[j*W +: W]);
        end
      end
      side_m1_r.neg  <= sq_side_r[RW-1].neg;
      side_m1_r.zero <= sq_side_r[RW-1].zero;
    end
  end

  // multiply stage 2: sum into numerator and denominator
  logic [DENW-1:0]    den_r;
  logic [2:0][NW-1:0] num_r;
  dv_side_t           side_m2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!point_r) begin
        den_r <= DENW'(1) << FRAC_BITS;
      end else if (falloff) begin
        den_r <= (DENW'(dhi_r) << RW) + DENW'(dlo_r);
      end else begin
        den_r <= DENW'(root_m1_r);
      end
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= NW'(np_r[i][0]) + (NW'(np_r[i][1]) << W) + (NW'(np_r[i][2]) << (2 * W));
      end
      side_m2_r <= side_m1_r;
    end
  end

  // dividers
  logic [2:0][W-1:0] quo;
  logic [2:0]        ovf;
  dv_side_t          dv_side_r [W+1];

  for (genvar i = 0; i < 3; i++) begin : g_div
    pdg_div #(.NW(NW), .DW(DENW), .QB(W)) u_div (
      .clk   (clk),
      .en    (en),
      .num_i (num_r[i]),
      .den_i (den_r),
      .quo_o (quo[i]),
      .ovf_o (ovf[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_side_r[0] <= side_m2_r;
      for (int j = 1; j <= W; j++) begin
        dv_side_r[j] <= dv_side_r[j-1];
      end
    end
  end

  // saturate, apply sign, output register
  logic [2:0][W-1:0] grav_r;
  logic              sat_r;
  logic [2:0][W-1:0] grav_nxt;
  logic              sat_nxt;

  always_comb begin
    logic [W-1:0] limit;
    logic [W-1:0] qs;
    logic         clip;
    sat_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      limit = dv_side_r[W].neg[i] ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - W'(1));
      clip  = ovf[i] | (quo[i] > limit);
      qs    = clip ? limit : quo[i];
      if (dv_side_r[W].zero) begin
        grav_nxt[i] = '0;
      end else begin
        grav_nxt[i] = dv_side_r[W].neg[i] ? (W'(0) - qs) : qs;
        sat_nxt     = sat_nxt | clip;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grav_r <= grav_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign out_grav_x    = grav_r[0];
  assign out_grav_y    = grav_r[1];
  assign out_grav_z    = grav_r[2];
  assign out_saturated = sat_r;

endmodule
